/* src/bbrq_pkg.sv */
// Shared codes, controller states and controller/datapath interface types.
package bbrq_pkg;

    localparam int POS_W = 10;
    localparam int CFG_W = 11;
    localparam int RES_W = 11;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_TOGGLE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [CFG_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;
    localparam logic [RES_W-1:0] RES_MAX             = 11'd2047;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_BIT_RD,
        ST_LEAF_WR,
        ST_PULL_RD,
        ST_PULL_WR,
        ST_Q_RD,
        ST_Q_ACC,
        ST_Q_FIN,
        ST_Q_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic bit_rd;
        logic leaf_wr;
        logic pull_rd;
        logic pull_wr;
        logic q_rd;
        logic q_acc;
        logic q_fin;
        logic q_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       in_range;
        logic       empty;
        logic       pull_last;
        logic       q_more;
        logic       out_busy;
    } dp_status_t;

endpackage

/* src/bbrq_ctrl.sv */
// Controller state machine sequencing tree updates and range queries.
module bbrq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bbrq_pkg::dp_status_t  stat,
    output bbrq_pkg::dp_cmd_t     cmd,
    output bbrq_pkg::state_t      state
);

    bbrq_pkg::state_t state_reg;
    bbrq_pkg::state_t state_next;

    assign state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbrq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            bbrq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bbrq_pkg::ST_DISPATCH;
                end
            end
            bbrq_pkg::ST_DISPATCH:
            begin
                cmd.load   = 1'b1;
                state_next = bbrq_pkg::ST_IDLE;
                case (stat.command)
                    bbrq_pkg::CMD_WRITE:
                    begin
                        if (stat.in_range)
                        begin
                            state_next = bbrq_pkg::ST_LEAF_WR;
                        end
                    end
                    bbrq_pkg::CMD_TOGGLE:
                    begin
                        if (stat.in_range)
                        begin
                            state_next = bbrq_pkg::ST_BIT_RD;
                        end
                    end
                    bbrq_pkg::CMD_QUERY:
                    begin
                        state_next = stat.empty ? bbrq_pkg::ST_Q_OUT : bbrq_pkg::ST_Q_RD;
                    end
                    default:
                    begin
                        state_next = bbrq_pkg::ST_IDLE;
                    end
                endcase
            end
            bbrq_pkg::ST_BIT_RD:
            begin
                cmd.bit_rd = 1'b1;
                state_next = bbrq_pkg::ST_LEAF_WR;
            end
            bbrq_pkg::ST_LEAF_WR:
            begin
                cmd.leaf_wr = 1'b1;
                state_next  = bbrq_pkg::ST_PULL_RD;
            end
            bbrq_pkg::ST_PULL_RD:
            begin
                cmd.pull_rd = 1'b1;
                state_next  = bbrq_pkg::ST_PULL_WR;
            end
            bbrq_pkg::ST_PULL_WR:
            begin
                cmd.pull_wr = 1'b1;
                state_next  = stat.pull_last ? bbrq_pkg::ST_IDLE : bbrq_pkg::ST_PULL_RD;
            end
            bbrq_pkg::ST_Q_RD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = stat.q_more ? bbrq_pkg::ST_Q_ACC : bbrq_pkg::ST_Q_FIN;
            end
            bbrq_pkg::ST_Q_ACC:
            begin
                cmd.q_acc  = 1'b1;
                state_next = bbrq_pkg::ST_Q_RD;
            end
            bbrq_pkg::ST_Q_FIN:
            begin
                cmd.q_fin  = 1'b1;
                state_next = bbrq_pkg::ST_Q_OUT;
            end
            bbrq_pkg::ST_Q_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.q_out  = 1'b1;
                    state_next = bbrq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbrq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/bbrq_datapath.sv */
// Datapath: request registers, bracket and node memories, join logic, result register.
module bbrq_datapath #(
    parameter int LENGTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bbrq_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [23:0]                   s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,
    input  bbrq_pkg::dp_cmd_t             cmd,
    output bbrq_pkg::dp_status_t          stat
);

    localparam int PW = $clog2(LENGTH);
    localparam int IW = PW + 1;
    localparam int LW = IW + 1;
    localparam int SW = PW + 2;
    localparam int VW = SW + 1;
    localparam int AW = (LW > 11) ? LW : 11;
    localparam int EW = (VW > 12) ? VW : 12;
    localparam int DEPTH = 2 * LENGTH;
    localparam logic signed [EW-1:0] SAT_LIM = signed'(EW'(bbrq_pkg::RES_MAX));
    localparam logic signed [SW-1:0] PLUS_ONE  = {{(SW-1){1'b0}}, 1'b1};
    localparam logic signed [SW-1:0] MINUS_ONE = {SW{1'b1}};

    logic [bbrq_pkg::CFG_W-1:0] active_length_reg;
    logic                       out_valid_reg;
    logic [bbrq_pkg::RES_W-1:0] out_data_reg;

    logic [1:0]                 cmd_reg;
    logic [bbrq_pkg::POS_W-1:0] sp_reg;
    logic [bbrq_pkg::POS_W-1:0] ep_reg;
    logic                       bv_reg;
    logic                       zero_reg;
    logic [IW-1:0]              node_idx_reg;
    logic [LW-1:0]              l_reg;
    logic [LW-1:0]              r_reg;
    logic signed [SW-1:0]       lo_sum_reg, lo_min_reg, hi_sum_reg, hi_min_reg;
    logic signed [SW-1:0]       all_sum_reg, all_min_reg;
    logic signed [SW-1:0]       a_sum_reg, a_min_reg, b_sum_reg, b_min_reg;
    logic                       bit_reg;

    logic signed [SW-1:0] sum_mem [DEPTH];
    logic signed [SW-1:0] min_mem [DEPTH];
    logic                 bit_mem [LENGTH];

    logic [AW-1:0] sp_w, ep_w, al_w, len_w, ep_clip, l_init, r_init;
    logic [LW-1:0] r_dec, l_next, r_next;
    logic [IW-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic          node_re, node_we, new_bit;
    logic signed [SW-1:0] wr_sum, wr_min, leaf_val;
    logic signed [SW-1:0] pull_sum, pull_min, pull_right;
    logic signed [SW-1:0] lo_sum_next, lo_min_next, lo_right;
    logic signed [SW-1:0] hi_sum_next, hi_min_next, hi_right;
    logic signed [SW-1:0] fin_sum, fin_min, fin_right;
    logic signed [VW-1:0] bal;
    logic signed [EW-1:0] bal_e;
    logic [bbrq_pkg::RES_W-1:0] sat_val, res_val;

    assign sp_w = AW'(sp_reg);
    assign ep_w = AW'(ep_reg);
    assign al_w = AW'(active_length_reg);

    always_comb
    begin
        if (al_w == '0)
        begin
            len_w = AW'(1);
        end
        else if (al_w > AW'(LENGTH))
        begin
            len_w = AW'(LENGTH);
        end
        else
        begin
            len_w = al_w;
        end
    end

    assign ep_clip = (ep_w >= len_w) ? (len_w - AW'(1)) : ep_w;
    assign l_init  = sp_w + AW'(LENGTH);
    assign r_init  = ep_clip + AW'(LENGTH) + AW'(1);
    assign r_dec   = r_reg - LW'(1);
    assign l_next  = (l_reg + LW'(l_reg[0])) >> 1;
    assign r_next  = (r_reg - LW'(r_reg[0])) >> 1;

    assign stat.command   = cmd_reg;
    assign stat.in_range  = sp_w < len_w;
    assign stat.empty     = sp_w > ep_clip;
    assign stat.pull_last = node_idx_reg == IW'(1);
    assign stat.q_more    = l_reg < r_reg;
    assign stat.out_busy  = out_valid_reg & ~m_tready;

    // node memory ports
    assign node_re   = cmd.pull_rd | (cmd.q_rd & stat.q_more);
    assign rd_a_addr = cmd.pull_rd ? {node_idx_reg[IW-2:0], 1'b0} : l_reg[IW-1:0];
    assign rd_b_addr = cmd.pull_rd ? {node_idx_reg[IW-2:0], 1'b1} : r_dec[IW-1:0];
    assign node_we   = cmd.leaf_wr | cmd.pull_wr;
    assign new_bit   = (cmd_reg == bbrq_pkg::CMD_TOGGLE) ? ~bit_reg : bv_reg;
    assign leaf_val  = new_bit ? PLUS_ONE : MINUS_ONE;
    assign wr_addr   = cmd.leaf_wr ? l_init[IW-1:0] : node_idx_reg;
    assign wr_sum    = cmd.leaf_wr ? leaf_val : pull_sum;
    assign wr_min    = cmd.leaf_wr ? leaf_val : pull_min;

    // join: left then right
    assign pull_sum   = a_sum_reg + b_sum_reg;
    assign pull_right = a_sum_reg + b_min_reg;
    assign pull_min   = (a_min_reg < pull_right) ? a_min_reg : pull_right;

    assign lo_right    = lo_sum_reg + a_min_reg;
    assign lo_sum_next = lo_sum_reg + a_sum_reg;
    assign lo_min_next = (lo_min_reg < lo_right) ? lo_min_reg : lo_right;

    assign hi_right    = b_sum_reg + hi_min_reg;
    assign hi_sum_next = b_sum_reg + hi_sum_reg;
    assign hi_min_next = (b_min_reg < hi_right) ? b_min_reg : hi_right;

    assign fin_right = lo_sum_reg + hi_min_reg;
    assign fin_sum   = lo_sum_reg + hi_sum_reg;
    assign fin_min   = (lo_min_reg < fin_right) ? lo_min_reg : fin_right;

    assign bal   = {all_sum_reg[SW-1], all_sum_reg} - {all_min_reg, 1'b0};
    assign bal_e = EW'(bal);

    always_comb
    begin
        if (bal_e < 0)
        begin
            sat_val = '0;
        end
        else if (bal_e > SAT_LIM)
        begin
            sat_val = bbrq_pkg::RES_MAX;
        end
        else
        begin
            sat_val = bal_e[bbrq_pkg::RES_W-1:0];
        end
    end

    assign res_val = zero_reg ? '0 : sat_val;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            sum_mem[wr_addr] <= wr_sum;
            min_mem[wr_addr] <= wr_min;
        end
        if (node_re)
        begin
            a_sum_reg <= sum_mem[rd_a_addr];
            a_min_reg <= min_mem[rd_a_addr];
            b_sum_reg <= sum_mem[rd_b_addr];
            b_min_reg <= min_mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.leaf_wr)
        begin
            bit_mem[sp_w[PW-1:0]] <= new_bit;
        end
        if (cmd.bit_rd)
        begin
            bit_reg <= bit_mem[sp_w[PW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_length_reg <= bbrq_pkg::ACTIVE_LENGTH_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_length_reg <= cfg_wr_data;
            end
            if (cmd.q_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= s_tuser;
            sp_reg  <= s_tdata[9:0];
            ep_reg  <= s_tdata[19:10];
            bv_reg  <= s_tdata[20];
        end
        if (cmd.load)
        begin
            l_reg      <= l_init[LW-1:0];
            r_reg      <= r_init[LW-1:0];
            zero_reg   <= stat.empty;
            lo_sum_reg <= '0;
            lo_min_reg <= '0;
            hi_sum_reg <= '0;
            hi_min_reg <= '0;
        end
        if (cmd.leaf_wr)
        begin
            node_idx_reg <= {1'b0, l_init[IW-1:1]};
        end
        else if (cmd.pull_wr)
        begin
            node_idx_reg <= node_idx_reg >> 1;
        end
        if (cmd.q_acc)
        begin
            l_reg <= l_next;
            r_reg <= r_next;
            if (l_reg[0])
            begin
                lo_sum_reg <= lo_sum_next;
                lo_min_reg <= lo_min_next;
            end
            if (r_reg[0])
            begin
                hi_sum_reg <= hi_sum_next;
                hi_min_reg <= hi_min_next;
            end
        end
        if (cmd.q_fin)
        begin
            all_sum_reg <= fin_sum;
            all_min_reg <= fin_min;
        end
        if (cmd.q_out)
        begin
            out_data_reg <= res_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - bbrq_pkg::RES_W){1'b0}}, out_data_reg};

endmodule

/* src/bracket_balance_range_query.sv */
// Top level: bracket string kept as a segment tree with point update and range balance query.
// Write: capture, dispatch, leaf write, then a node-memory read and a write-back for each tree level up
// to the root before the next ready; a toggle first reads the stored bit.
// Query: a read of two nodes and an accumulate step per level, then finish and output; empty goes to output.
// One request at a time; a result waits in the output register while the next request is taken.
// Reset clears controller, output valid and active_length (1024); memories are not cleared.
module bracket_balance_range_query #(
    parameter int LENGTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bbrq_pkg::CFG_W-1:0]  cfg_wr_data,    // active_length
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,        // start_position, end_position, bracket_value
    input  logic [1:0]                  s_tuser,        // command
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata         // insertions_needed
);

    bbrq_pkg::dp_cmd_t    cmd;
    bbrq_pkg::dp_status_t stat;
    bbrq_pkg::state_t     state;

    bbrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    bbrq_datapath #(
        .LENGTH (LENGTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_out |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten while held");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state == bbrq_pkg::ST_Q_OUT))
        else $error("result raised outside query output step");

    a_pull_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state == bbrq_pkg::ST_PULL_WR && stat.pull_last) |=> state == bbrq_pkg::ST_IDLE)
        else $error("update did not end at root");

endmodule

/* sim/bracket_balance_range_query_test.sv */
// Self-checking testbench for bracket_balance_range_query: stream requests, predict, compare.
module bracket_balance_range_query_test;

    localparam int          LENGTH        = 1024;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          PHASE_QUOTA   = 45;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [bbrq_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [23:0]                s_tdata = '0;
    logic [1:0]                 s_tuser = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [15:0]                m_tdata;

    // Model of the bracket string and the active_length register
    bit                         bracket_bits [0:LENGTH-1];
    logic [bbrq_pkg::CFG_W-1:0] length_setting = bbrq_pkg::ACTIVE_LENGTH_RESET;

    logic [bbrq_pkg::RES_W-1:0] expected_insertions [$];
    int               mismatch_count = 0;
    int               request_count = 0;
    int               query_count = 0;
    int               setting_count = 0;
    int               burst_left = 0;
    int               ready_pct = 100;
    int               ready_cycles = 0;

    bracket_balance_range_query #(.LENGTH(LENGTH)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int unsigned usable_length();
        if (length_setting == 0)
            return 1;
        if (length_setting > LENGTH)
            return LENGTH;
        return 32'(length_setting);
    endfunction

    function automatic logic [bbrq_pkg::RES_W-1:0] insertions_for(int unsigned first,
                                                                  int unsigned last);
        int balance;
        int lowest;
        int fix;
        balance = 0;
        lowest  = 0;
        for (int unsigned p = first; p <= last; p++)
        begin
            balance += bracket_bits[p] ? 1 : -1;
            if (balance < lowest)
                lowest = balance;
        end
        fix = balance - 2 * lowest;
        if (fix < 0)
            fix = 0;
        if (fix > int'(bbrq_pkg::RES_MAX))
            fix = int'(bbrq_pkg::RES_MAX);
        return fix[bbrq_pkg::RES_W-1:0];
    endfunction

    // Update the string model; queue the answer of a query. Return 0 for an ignored request.
    function automatic bit predict_request(logic [1:0] cmd, logic [bbrq_pkg::POS_W-1:0] sp,
                                           logic [bbrq_pkg::POS_W-1:0] ep, logic bv);
        int unsigned len;
        int unsigned last;
        len = usable_length();
        case (cmd)
            bbrq_pkg::CMD_WRITE, bbrq_pkg::CMD_TOGGLE:
            begin
                if (32'(sp) >= len)
                    return 1'b0;
                bracket_bits[sp] = (cmd == bbrq_pkg::CMD_WRITE) ? bv : ~bracket_bits[sp];
                return 1'b1;
            end
            bbrq_pkg::CMD_QUERY:
            begin
                last = (32'(ep) >= len) ? len - 1 : 32'(ep);
                if (32'(sp) > last)
                    expected_insertions.push_back('0);
                else
                    expected_insertions.push_back(insertions_for(32'(sp), last));
                query_count++;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [bbrq_pkg::POS_W-1:0] sp,
                                input logic [bbrq_pkg::POS_W-1:0] ep, input logic bv,
                                output bit effective);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = int'($urandom_range(1, 16));
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 10));
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, bv, ep, sp};
        do
            @(posedge clk);
        while (!s_tready);
        effective = predict_request(cmd, sp, ep, bv);
        request_count++;
    endtask

    task automatic send(input logic [1:0] cmd, input int sp, input int ep, input logic bv);
        bit effective;
        send_request(cmd, sp[bbrq_pkg::POS_W-1:0], ep[bbrq_pkg::POS_W-1:0], bv, effective);
    endtask

    // Hold the sender until every result is back, then let the block settle
    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (expected_insertions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [bbrq_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        length_setting  = value;
        setting_count++;
    endtask

    // Receiver: ready rate is redrawn from time to time among 100, 75, 40 and 10 percent
    always @(posedge clk)
    begin
        if (ready_cycles == 0)
        begin
            ready_cycles = int'($urandom_range(50, 300));
            case ($urandom_range(0, 4))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 40;
                3: ready_pct = 10;
                default: ready_pct = 100;
            endcase
        end
        ready_cycles--;
        m_tready <= (int'($urandom_range(1, 100)) <= ready_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_insertions.size() == 0)
            begin
                $error("insertions_needed: no result expected, actual %0d",
                       m_tdata[bbrq_pkg::RES_W-1:0]);
                mismatch_count++;
            end
            else if (m_tdata[bbrq_pkg::RES_W-1:0] !== expected_insertions[0])
            begin
                $error("insertions_needed: expected %0d, actual %0d",
                       expected_insertions[0], m_tdata[bbrq_pkg::RES_W-1:0]);
                mismatch_count++;
                void'(expected_insertions.pop_front());
            end
            else
                void'(expected_insertions.pop_front());
        end
    end

    // Closing half then opening half: every position defined, full-range answer is the maximum
    task automatic test_fill_halves();
        for (int p = 0; p < LENGTH; p++)
            send(bbrq_pkg::CMD_WRITE, p, int'($urandom), p >= LENGTH / 2);
    endtask

    task automatic test_directed();
        send(bbrq_pkg::CMD_QUERY, 0, 1023, 1'b0);
        send(bbrq_pkg::CMD_QUERY, 512, 1023, 1'b1);
        send(bbrq_pkg::CMD_QUERY, 0, 0, 1'b0);
        send(bbrq_pkg::CMD_QUERY, 1023, 1023, 1'b1);
        send(bbrq_pkg::CMD_QUERY, 600, 100, 1'b0);
        send(bbrq_pkg::CMD_WRITE, 0, 1023, 1'b1);
        send(bbrq_pkg::CMD_WRITE, 1023, 0, 1'b0);
        send(bbrq_pkg::CMD_TOGGLE, 511, 0, 1'b0);
        send(bbrq_pkg::CMD_TOGGLE, 512, 1023, 1'b1);
        send(CMD_UNUSED, 3, 1000, 1'b1);
        send(bbrq_pkg::CMD_QUERY, 0, 1023, 1'b0);
        write_length(11'd10);
        send(bbrq_pkg::CMD_WRITE, 500, 0, 1'b1);
        send(bbrq_pkg::CMD_TOGGLE, 10, 0, 1'b0);
        send(bbrq_pkg::CMD_QUERY, 0, 1023, 1'b0);
        send(bbrq_pkg::CMD_QUERY, 10, 20, 1'b0);
        send(bbrq_pkg::CMD_QUERY, 9, 9, 1'b0);
        write_length(11'd0);
        send(bbrq_pkg::CMD_QUERY, 0, 1023, 1'b0);
        send(bbrq_pkg::CMD_WRITE, 1, 0, 1'b1);
        send(bbrq_pkg::CMD_WRITE, 0, 0, 1'b0);
        send(bbrq_pkg::CMD_QUERY, 0, 5, 1'b1);
        write_length(11'd2047);
        send(bbrq_pkg::CMD_QUERY, 0, 1023, 1'b0);
    endtask

    task automatic random_request(input int unsigned len, output bit effective);
        int unsigned                pick;
        int unsigned                draw;
        logic [bbrq_pkg::POS_W-1:0] sp;
        logic [bbrq_pkg::POS_W-1:0] ep;
        logic [1:0]                 cmd;
        logic                       bv;
        pick = $urandom_range(0, 99);
        draw = $urandom_range(0, len - 1);
        sp   = draw[bbrq_pkg::POS_W-1:0];
        draw = $urandom;
        ep   = draw[bbrq_pkg::POS_W-1:0];
        draw = $urandom_range(0, 1);
        bv   = draw[0];
        if (pick < 40)
            cmd = bbrq_pkg::CMD_WRITE;
        else if (pick < 55)
            cmd = bbrq_pkg::CMD_TOGGLE;
        else if (pick < 90)
        begin
            cmd = bbrq_pkg::CMD_QUERY;
            if ($urandom_range(0, 4) == 0)
            begin
                draw = $urandom;
                sp   = draw[bbrq_pkg::POS_W-1:0];
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                draw = 32'(sp) + $urandom_range(0, 15);
                if (draw >= len)
                    draw = len - 1;
                ep = draw[bbrq_pkg::POS_W-1:0];
            end
            else
            begin
                draw = $urandom_range(32'(sp), len - 1);
                ep   = draw[bbrq_pkg::POS_W-1:0];
            end
        end
        else if (pick < 95)
        begin
            cmd  = ($urandom_range(0, 1) == 0) ? bbrq_pkg::CMD_WRITE : bbrq_pkg::CMD_TOGGLE;
            draw = $urandom;
            sp   = draw[bbrq_pkg::POS_W-1:0];
        end
        else
        begin
            cmd  = CMD_UNUSED;
            draw = $urandom;
            sp   = draw[bbrq_pkg::POS_W-1:0];
        end
        send_request(cmd, sp, ep, bv, effective);
    endtask

    task automatic test_random_phases();
        logic [bbrq_pkg::CFG_W-1:0] lengths [10];
        int                         counted;
        int unsigned                draw;
        bit                         effective;
        lengths = '{11'd1024, 11'd37, 11'd1, 11'd2, 11'd0, 11'd2047, 11'd1025,
                    11'd3, 11'd1023, 11'd1024};
        draw = $urandom_range(3, 1022);
        lengths[7] = draw[bbrq_pkg::CFG_W-1:0];
        foreach (lengths[i])
        begin
            write_length(lengths[i]);
            counted = 0;
            while (counted < PHASE_QUOTA)
            begin
                random_request(usable_length(), effective);
                if (effective)
                    counted++;
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        foreach (bracket_bits[p])
            bracket_bits[p] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_halves();
        test_directed();
        test_random_phases();
        wait_drained();
        $display("Ran %0d requests, %0d queries checked, across %0d active_length settings",
                 request_count, query_count, setting_count);
        $display("Settings included 0, 1, 2, 1023, 1024, 1025 and 2047, with ignored requests mixed in");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
src/bbrq_pkg.sv
src/bbrq_ctrl.sv
src/bbrq_datapath.sv
src/bracket_balance_range_query.sv
sim/bracket_balance_range_query_test.sv
